[design/gbb_pkg.sv]
// gbb_pkg: shared types, constants and helper functions of the gray box blur block
// used by gbb_queue, gbb_front, gbb_back and the top level; depends on nothing
`default_nettype none
package gbb_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SLOT_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int RAM_DEPTH  = RING_ROWS * MAX_WIDTH;
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 14;
    localparam int RECIP_SH   = 18;
    localparam int RECIP_W    = 19;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [1:0]         rad;
        logic [CNT_W-1:0]   total;
        logic [11:0]        delay;
        logic [RECIP_W-1:0] recip;
        logic [3:0]         ring;
    } cfg_t;

    typedef struct packed {
        logic       is_pixel;
        logic [7:0] gray;
    } qitem_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_LAST,
        ST_DIV,
        ST_OUT
    } state_t;

    // divide by three through a reciprocal, exact for sums below 768
    function automatic logic [7:0] gray_of(input logic [9:0] s);
        logic [19:0] p;
        p = {10'b0, s} * 20'd683;
        return p[18:11];
    endfunction

    // reciprocal of the window area scaled by 2^18, exact for every window sum
    function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] rad);
        logic [RECIP_W-1:0] m;
        case (rad)
            2'd0:    m = 19'd262144;
            2'd1:    m = 19'd29128;
            2'd2:    m = 19'd10486;
            default: m = 19'd5350;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

[design/gbb_ram.sv]
// gbb_ram: generic single port ram with registered read
// no dependencies
`default_nettype none
module gbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[design/gbb_queue.sv]
// gbb_queue: short queue of classified items between front and back
// depends on gbb_pkg
`default_nettype none
module gbb_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire gbb_pkg::qitem_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output gbb_pkg::qitem_t      head,
    output logic                 empty
);
    import gbb_pkg::*;

    qitem_t            buf_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = buf_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg + QPTR_W'(push);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            buf_reg[wr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

[design/gbb_front.sv]
// gbb_front: input side, classifies items and converts pixels to gray
// depends on gbb_pkg
`default_nettype none
module gbb_front (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        q_full,
    output logic             q_push,
    output gbb_pkg::qitem_t  q_item
);
    import gbb_pkg::*;

    logic [9:0] rgb_sum;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign rgb_sum  = {2'b0, s_tdata[7:0]} + {2'b0, s_tdata[15:8]} + {2'b0, s_tdata[23:16]};

    always_comb begin
        q_item.is_pixel = !s_tuser;
        q_item.gray     = gray_of(rgb_sum);
    end
endmodule
`default_nettype wire

[design/gbb_back.sv]
// gbb_back: line store writes, window sum over the ring and division by the area
// depends on gbb_pkg and gbb_ram
`default_nettype none
module gbb_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire gbb_pkg::cfg_t   cfg,
    input  wire logic            restart,
    input  wire gbb_pkg::qitem_t head,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import gbb_pkg::*;

    state_t            state_reg, state_next;
    logic [ROW_W:0]    in_row_reg, in_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [CNT_W-1:0]  in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [2:0]        dy_reg, dy_next, dx_reg, dx_next;
    logic [SUM_W-1:0]  sum_reg, sum_next, sh_reg, sh_next;
    logic              rv_reg, rv_next;
    logic [7:0]        res_reg, res_next;
    logic              last_reg, last_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;

    logic [2:0]        side_m1;
    logic signed [12:0] tap_r, tap_c;
    logic signed [5:0] tap_s;
    logic [SLOT_W-1:0] tap_slot;
    logic              tap_ok, tap_end;
    logic [CNT_W:0]    need;
    logic              fire;
    logic [SUM_W-1:0]  sum_acc;
    logic [SUM_W+RECIP_W-1:0] scaled;

    gbb_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.gray),
        .rdata (ram_rdata)
    );

    assign side_m1 = {cfg.rad, 1'b0};
    assign tap_end = (dy_reg == side_m1) && (dx_reg == side_m1);
    assign sum_acc = sum_reg + (rv_reg ? {6'b0, ram_rdata} : '0);
    assign scaled  = {{RECIP_W{1'b0}}, sh_reg} * {{SUM_W{1'b0}}, cfg.recip};

    always_comb begin
        tap_r = $signed({3'b0, out_row_reg}) + $signed({10'b0, dy_reg})
              - $signed({11'b0, cfg.rad});
        tap_c = $signed({3'b0, out_col_reg}) + $signed({10'b0, dx_reg})
              - $signed({11'b0, cfg.rad});
        tap_ok = (tap_r >= 0) && (tap_r < $signed({2'b0, cfg.h}))
              && (tap_c >= 0) && (tap_c < $signed({2'b0, cfg.w}));
        tap_s = $signed({3'b0, out_slot_reg}) + $signed({3'b0, dy_reg})
              - $signed({4'b0, cfg.rad});
        if (tap_s < 0) begin
            tap_s = tap_s + $signed({2'b0, cfg.ring});
        end else if (tap_s >= $signed({2'b0, cfg.ring})) begin
            tap_s = tap_s - $signed({2'b0, cfg.ring});
        end
        tap_slot = tap_s[SLOT_W-1:0];
        need = {1'b0, emit_reg} + (CNT_W+1)'(cfg.delay) + (CNT_W+1)'(1);
        if (need > {1'b0, cfg.total}) begin
            need = {1'b0, cfg.total};
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (!q_empty) state_next = ST_CHECK;
            ST_CHECK: begin
                if (emit_reg < cfg.total && {1'b0, in_cnt_reg} >= need) begin
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:   if (tap_end) state_next = ST_LAST;
            ST_LAST:  state_next = ST_DIV;
            ST_DIV:   state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = {in_slot_reg, in_col_reg};
        fire          = 1'b0;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        in_cnt_next   = in_cnt_reg;
        emit_next     = emit_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        dy_next       = dy_reg;
        dx_next       = dx_reg;
        sum_next      = sum_reg;
        rv_next       = 1'b0;
        sh_next       = sh_reg;
        res_next      = res_reg;
        last_next     = last_reg;
        m_tvalid      = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (head.is_pixel && in_row_reg < cfg.h) begin
                        ram_we      = 1'b1;
                        in_cnt_next = in_cnt_reg + CNT_W'(1);
                        if ({1'b0, in_col_reg} == cfg.w - DIM_W'(1)) begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + (ROW_W+1)'(1);
                            if ({1'b0, in_slot_reg} == cfg.ring - 4'd1) begin
                                in_slot_next = '0;
                            end else begin
                                in_slot_next = in_slot_reg + SLOT_W'(1);
                            end
                        end else begin
                            in_col_next = in_col_reg + COL_W'(1);
                        end
                    end
                end
            end
            ST_CHECK: begin
                dy_next  = '0;
                dx_next  = '0;
                sum_next = '0;
            end
            ST_SUM: begin
                ram_addr = {tap_slot, tap_c[COL_W-1:0]};
                rv_next  = tap_ok;
                sum_next = sum_acc;
                if (dx_reg == side_m1) begin
                    dx_next = '0;
                    dy_next = dy_reg + 3'd1;
                end else begin
                    dx_next = dx_reg + 3'd1;
                end
            end
            ST_LAST: begin
                sh_next = sum_acc;
            end
            ST_DIV: begin
                res_next  = scaled[RECIP_SH +: 8];
                last_next = (emit_reg == cfg.total - CNT_W'(1));
            end
            ST_OUT: begin
                if (m_tready) begin
                    fire      = 1'b1;
                    emit_next = emit_reg + CNT_W'(1);
                    if ({1'b0, out_col_reg} == cfg.w - DIM_W'(1)) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                        if ({1'b0, out_slot_reg} == cfg.ring - 4'd1) begin
                            out_slot_next = '0;
                        end else begin
                            out_slot_next = out_slot_reg + SLOT_W'(1);
                        end
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
            default: ;
        endcase
        // frame end or register write starts a new frame
        if (restart || (fire && emit_next >= cfg.total)) begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_slot_next  = '0;
            in_cnt_next   = '0;
            emit_next     = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_slot_next = '0;
        end
    end

    assign m_tdata = res_reg;
    assign m_tlast = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_cnt_reg   <= '0;
            emit_reg     <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            rv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            in_cnt_reg   <= in_cnt_next;
            emit_reg     <= emit_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            rv_reg       <= rv_next;
        end
        dy_reg   <= dy_next;
        dx_reg   <= dx_next;
        sum_reg  <= sum_next;
        sh_reg   <= sh_next;
        res_reg  <= res_next;
        last_reg <= last_next;
    end
endmodule
`default_nettype wire

[design/gray_box_blur_zero_pad_top.sv]
// gray_box_blur_zero_pad_top: gray conversion and zero padded box blur, top level
// depends on gbb_pkg, gbb_front, gbb_queue, gbb_back
//
// Pixels enter in raster order; each is turned into gray and written to a ring of
// line buffers, then the window mean for the pending output is summed one tap per
// cycle from the single ram port and scaled by the reciprocal of the window area.
// An item that gives no result passes only the idle and check states; one that
// does then passes the sum, last, divide and output states and waits on m_tready;
// a four entry queue lets input items be taken while the back end works. Output k
// leaves on the item that brings input pixel k + radius*width + radius; after the
// frame's last pixel, drain items (s_tuser high) push out the rest, the final one
// with m_tlast. A write to width, height or radius restarts the frame.
`default_nettype none
module gray_box_blur_zero_pad_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // red, green, blue
    input  wire logic        s_tuser,  // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // blurred_gray
    output logic             m_tlast
);
    import gbb_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next, height_reg, height_next;
    logic [1:0]       radius_reg, radius_next;
    cfg_t             cfg_reg, cfg_next;
    logic             restart;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [21:0]      prod;

    logic   q_full, q_push, q_pop, q_empty;
    qitem_t q_in, q_head;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        radius_next = radius_reg;
        restart     = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  begin width_next = cfg_wdata; restart = 1'b1; end
                REG_HEIGHT: begin height_next = cfg_wdata; restart = 1'b1; end
                REG_RADIUS: begin radius_next = cfg_wdata[1:0]; restart = 1'b1; end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
        else w_eff = width_reg;
        if (height_reg == '0) h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
        else h_eff = height_reg;
        prod           = {11'b0, w_eff} * {11'b0, h_eff};
        cfg_next.w     = w_eff;
        cfg_next.h     = h_eff;
        cfg_next.rad   = radius_reg;
        cfg_next.total = prod[CNT_W-1:0];
        cfg_next.delay = 12'({1'b0, w_eff} * {10'b0, radius_reg}) + {10'b0, radius_reg};
        cfg_next.recip = recip_of(radius_reg);
        cfg_next.ring  = {1'b0, radius_reg, 1'b0} + 4'd2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1024);
            height_reg <= DIM_W'(1024);
            radius_reg <= 2'd1;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            radius_reg <= radius_next;
        end
        cfg_reg <= cfg_next;
    end

    gbb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    gbb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    gbb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .restart  (restart),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

[design/gbb_checker.sv]
// gbb_checker: port level assertions for the gray box blur top level
// bound to gray_box_blur_zero_pad_top; depends on nothing
`default_nettype none
module gbb_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_gap_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result items back to back");

    a_gap_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |-> ##2 !m_tvalid)
        else $error("result item too soon after previous");
endmodule

bind gray_box_blur_zero_pad_top gbb_checker u_gbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

[bench/gray_box_blur_zero_pad_top_tb.sv]
// gray_box_blur_zero_pad_top_tb: self-checking bench for the gray box blur block
// drives pixel and drain items with random idling, predicts each blurred output
// depends on gbb_pkg and gray_box_blur_zero_pad_top
`default_nettype none
module gray_box_blur_zero_pad_top_tb;
    import gbb_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam bit REQ_PIXEL = 1'b0;
    localparam bit REQ_DRAIN = 1'b1;
    localparam int SETTLE = 400;
    localparam int RANDOM_ITEMS = 650;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_WIDTH;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int  errors = 0;
    int  n_items = 0;
    bit  quiet = 1'b0;

    always #1 aclk = ~aclk;

    gray_box_blur_zero_pad_top DUT (.*);

    task automatic report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    typedef struct {
        logic [7:0] gray;
        logic       last;
    } blur_out_t;

    class blur_scoreboard;
        logic [10:0] width_reg, height_reg;
        logic [1:0]  radius_reg;
        logic [7:0]  gray_rows[8][MAX_WIDTH];
        int          row, col, emitted;
        blur_out_t   expected_q[$];

        function new();
            width_reg = 11'd1024;
            height_reg = 11'd1024;
            radius_reg = 2'd1;
            foreach (gray_rows[i, j]) gray_rows[i][j] = '0;
            restart();
        endfunction

        function void restart();
            row = 0;
            col = 0;
            emitted = 0;
        endfunction

        function int clamp_dim(logic [10:0] v, int maxv);
            if (v == 0) return 1;
            return (v > maxv) ? maxv : int'(v);
        endfunction

        function void configure(logic [1:0] idx, logic [10:0] val);
            case (idx)
                REG_WIDTH:  width_reg = val;
                REG_HEIGHT: height_reg = val;
                REG_RADIUS: radius_reg = val[1:0];
                default:    return;
            endcase
            restart();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(bit req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int w, h, rad, ring, total, received, need, ey, ex, yy, xx, sum, side;
            blur_out_t o;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            rad = radius_reg;
            ring = 2 * rad + 2;
            side = 2 * rad + 1;
            total = w * h;
            if (req == REQ_PIXEL && row < h) begin
                gray_rows[row % ring][col] = 8'((int'(r) + int'(g) + int'(b)) / 3);
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                end
            end
            received = (row >= h) ? total : row * w + col;
            if (emitted >= total) return;
            need = emitted + rad * w + rad + 1;
            if (need > total) need = total;
            if (received < need) return;
            ey = emitted / w;
            ex = emitted % w;
            sum = 0;
            for (int dy = -rad; dy <= rad; dy++) begin
                yy = ey + dy;
                if (yy < 0 || yy >= h) continue;
                for (int dx = -rad; dx <= rad; dx++) begin
                    xx = ex + dx;
                    if (xx < 0 || xx >= w) continue;
                    sum += gray_rows[yy % ring][xx];
                end
            end
            o.gray = 8'(sum / (side * side));
            o.last = (emitted == total - 1);
            expected_q.push_back(o);
            emitted++;
            if (emitted >= total) restart();
        endfunction

        task check(logic [7:0] gray, logic last);
            blur_out_t o;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected output gray=%0d last=%0b", gray, last));
                return;
            end
            o = expected_q.pop_front();
            if (gray !== o.gray)
                report($sformatf("blurred_gray %0d, expected %0d", gray, o.gray));
            if (last !== o.last)
                report($sformatf("last_pixel %0b, expected %0b", last, o.last));
        endtask
    endclass

    blur_scoreboard sb = new();

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
        if (aresetn && m_tvalid && m_tready)
            sb.check(m_tdata, m_tlast);
    end

    int stall_left = 0;
    always @(negedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(bit req, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        n_items++;
    endtask

    task automatic send_pixel();
        send(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_drain();
        send(REQ_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.configure(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [10:0] w, logic [10:0] h, logic [1:0] rad);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // full frame with occasional stray drains and extra pixels, then flush
    task automatic run_frame(int w, int h, int rad);
        int delay;
        delay = rad * w + rad;
        setup(11'(w), 11'(h), 2'(rad));
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 9) == 0) send_drain();
            send_pixel();
        end
        for (int i = 0; i < delay + $urandom_range(0, 2); i++) begin
            if ($urandom_range(0, 5) == 0) send_pixel();
            else send_drain();
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: 4x3 frame, radius 1, extreme pixels and drain corner cases
        setup(11'd4, 11'd3, 2'd1);
        send(REQ_DRAIN, 8'hff, 8'hff, 8'hff);
        send(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        send(REQ_PIXEL, 8'hff, 8'hff, 8'hff);
        send(REQ_PIXEL, 8'hff, 8'h00, 8'h00);
        send(REQ_PIXEL, 8'h00, 8'hff, 8'h00);
        send(REQ_PIXEL, 8'h00, 8'h00, 8'hff);
        send(REQ_PIXEL, 8'hff, 8'hff, 8'hfe);
        for (int i = 0; i < 6; i++) send_pixel();
        send(REQ_PIXEL, 8'h55, 8'haa, 8'h01);
        send(REQ_PIXEL, 8'hff, 8'hff, 8'hff);
        for (int i = 0; i < 4; i++) send_drain();
        write_reg(REG_UNUSED, 11'd5);
        setup(11'd1, 11'd1, 2'd0);
        send(REQ_PIXEL, 8'hff, 8'hff, 8'hff);
        send_drain();
        // register extremes, partial frames dropped by the next write
        setup(11'd1024, 11'd2, 2'd3);
        for (int i = 0; i < 10; i++) send_pixel();
        setup(11'd1, 11'd1024, 2'd3);
        for (int i = 0; i < 20; i++) send_pixel();
        setup(11'd0, 11'd2047, 2'd2);
        for (int i = 0; i < 12; i++) send_pixel();
        setup(11'd2047, 11'd0, 2'd0);
        for (int i = 0; i < 5; i++) send_pixel();

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            if (n_items > RANDOM_ITEMS - 120) quiet = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                setup(11'($urandom_range(1, 40)), 11'($urandom_range(1, 6)),
                      2'($urandom_range(0, 3)));
                for (int i = 0; i < $urandom_range(1, 15); i++) send_pixel();
            end else if ($urandom_range(0, 9) == 0) begin
                run_frame($urandom_range(8, 20), $urandom_range(2, 4), $urandom_range(0, 3));
            end else begin
                run_frame($urandom_range(1, 7), $urandom_range(1, 6), $urandom_range(0, 3));
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (sb.pending() != 0) report("outputs still expected at end");
        if (errors == 0) begin
            $display("gray_box_blur_zero_pad_top_tb passed");
        end else begin
            $display("gray_box_blur_zero_pad_top_tb failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("gray_box_blur_zero_pad_top_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
